/* rtl/pks_pkg.sv */
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types and constants of the particle key sorter.
// ----------------------------------------------------------------------------
package pks_pkg;

    localparam int COORD_W           = 32;
    localparam int GRID_W            = 13;
    localparam int PROD_W            = COORD_W + GRID_W;
    localparam int KEY_W             = PROD_W + 1;
    localparam int MAX_PARTICLES_DEF = 64;

    localparam logic [GRID_W-1:0] GRID_NY_RESET = 13'd64;

    typedef struct packed {
        logic        [COORD_W-1:0] pos_x;
        logic        [COORD_W-1:0] pos_y;
        logic        [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic signed [COORD_W-1:0] vel_z;
        logic                      last;
    } particle_in_t;

    typedef struct packed {
        logic        [COORD_W-1:0] out_pos_x;
        logic        [COORD_W-1:0] out_pos_y;
        logic        [COORD_W-1:0] out_pos_z;
        logic signed [COORD_W-1:0] out_vel_x;
        logic signed [COORD_W-1:0] out_vel_y;
        logic signed [COORD_W-1:0] out_vel_z;
        logic                      out_last;
    } particle_out_t;

    // One stored particle: sort key plus payload.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0] vel_x;
        logic [COORD_W-1:0] vel_y;
        logic [COORD_W-1:0] vel_z;
    } entry_t;

endpackage

/* rtl/pks_ram.sv */
// ----------------------------------------------------------------------------
// pks_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/particle_key_sort.sv */
// ----------------------------------------------------------------------------
// particle_key_sort
// Collects particles, keeps them in ascending spatial key order, emits them.
// ----------------------------------------------------------------------------
// Particles arrive on the item channel (item_valid/item_stall). Each one gets
// the key pos_x * grid_ny + pos_y and is inserted into a sorted RAM; equal
// keys keep arrival order. Insertion walks down from the top entry one entry
// per cycle, reading one entry and writing it one place up. Particles beyond
// MAX_PARTICLES are dropped.
// The item with last set is stored too if there is room, then every held
// particle is sent on the result channel (res_valid/res_stall) in key order,
// out_last on the final one. Each result passes through RAM read, load of the
// output register and transfer. A stalled result holds still; no new item is
// taken until the whole set has gone out. The user must write grid_ny through
// cfg_we/cfg_data only while the block is idle; the block does not check it.
// Reset empties the set and sets grid_ny to 64; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module particle_key_sort
    import pks_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  particle_in_t        item,
    output logic                res_valid,
    input  logic                res_stall,
    output particle_out_t       res,
    input  logic                cfg_we,
    input  logic [GRID_W-1:0]   cfg_data
);

    localparam int ADDR_W  = $clog2(MAX_PARTICLES);
    localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
    localparam int ENTRY_W = $bits(entry_t);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WNEW  = 3'd2;
    localparam logic [2:0] ST_ERD   = 3'd3;
    localparam logic [2:0] ST_EWAIT = 3'd4;
    localparam logic [2:0] ST_EHOLD = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [GRID_W-1:0] grid_ny_reg;
    logic              valid_reg, valid_next;
    entry_t            new_reg, new_next;
    logic              last_reg, last_next;
    particle_out_t     out_reg, out_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  cnt_dec;
    logic [ADDR_W-1:0] top_addr, idx_inc, idx_dec;
    logic              full, item_xfer, res_xfer;

    pks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign prod      = PROD_W'(item.pos_x) * PROD_W'(grid_ny_reg);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign top_addr  = cnt_dec[ADDR_W-1:0];
    assign idx_inc   = idx_reg + ADDR_W'(1);
    assign idx_dec   = idx_reg - ADDR_W'(1);
    assign full      = (count_reg == CNT_W'(MAX_PARTICLES));
    assign item_stall = (state_reg != ST_IDLE);
    assign item_xfer = item_valid && !item_stall;
    assign res_valid = valid_reg;
    assign res_xfer  = valid_reg && !res_stall;
    assign res       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        new_next   = new_reg;
        last_next  = last_reg;
        out_next   = out_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_inc;
        ram_wdata  = new_reg;
        ram_raddr  = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = top_addr;
                if (item_xfer)
                begin
                    new_next.key   = {1'b0, prod} + KEY_W'(item.pos_y);
                    new_next.pos_x = item.pos_x;
                    new_next.pos_y = item.pos_y;
                    new_next.pos_z = item.pos_z;
                    new_next.vel_x = item.vel_x;
                    new_next.vel_y = item.vel_y;
                    new_next.vel_z = item.vel_z;
                    last_next      = item.last;
                    if (full)
                    begin
                        idx_next   = '0;
                        state_next = item.last ? ST_ERD : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        idx_next   = '0;
                        state_next = ST_WNEW;
                    end
                    else
                    begin
                        idx_next   = top_addr;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                ram_we = 1'b1;
                if (ram_rdata.key > new_reg.key)
                begin
                    // Larger key moves up one place; keep walking down.
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_WNEW;
                    end
                    else
                    begin
                        ram_raddr = idx_dec;
                        idx_next  = idx_dec;
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    idx_next   = '0;
                    state_next = last_reg ? ST_ERD : ST_IDLE;
                end
            end

            ST_WNEW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                count_next = count_reg + CNT_W'(1);
                idx_next   = '0;
                state_next = last_reg ? ST_ERD : ST_IDLE;
            end

            ST_ERD:
            begin
                state_next = ST_EWAIT;
            end

            ST_EWAIT:
            begin
                out_next.out_pos_x = ram_rdata.pos_x;
                out_next.out_pos_y = ram_rdata.pos_y;
                out_next.out_pos_z = ram_rdata.pos_z;
                out_next.out_vel_x = ram_rdata.vel_x;
                out_next.out_vel_y = ram_rdata.vel_y;
                out_next.out_vel_z = ram_rdata.vel_z;
                out_next.out_last  = (idx_reg == top_addr);
                valid_next         = 1'b1;
                state_next         = ST_EHOLD;
            end

            ST_EHOLD:
            begin
                if (res_xfer)
                begin
                    valid_next = 1'b0;
                    if (out_reg.out_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_ERD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            valid_reg   <= 1'b0;
            grid_ny_reg <= GRID_NY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                grid_ny_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg  <= new_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("held count above capacity");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (state_reg == ST_EHOLD))
        else $error("result valid outside the hold state");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && res.out_last) |=> (count_reg == '0 && state_reg == ST_IDLE))
        else $error("set not cleared after the final transfer");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERD) |-> (count_reg != '0))
        else $error("emission started on an empty set");
`endif

endmodule

/* test/particle_key_sort_test.sv */
// ----------------------------------------------------------------------------
// particle_key_sort_test
// Checks sets of particles against a predicted key-ordered emission.
// ----------------------------------------------------------------------------
// Particles go in with random gaps or in bursts and come out under random
// stalls. A small sorted store inside the checker follows the block: it
// inserts each accepted particle after all held ones with an equal key, and
// on a last particle it queues the whole set as expected transfers. Sets run
// under several grid_ny settings, written only while the block is idle.
// ----------------------------------------------------------------------------
class sort_scoreboard;
    localparam int CAP = pks_pkg::MAX_PARTICLES_DEF;

    pks_pkg::particle_in_t  held[$];
    logic [63:0]            held_key[$];
    pks_pkg::particle_out_t expected_out[$];
    logic [12:0]            grid_ny;
    int                     mismatches;

    function new();
        grid_ny = pks_pkg::GRID_NY_RESET;
        mismatches = 0;
    endfunction

    function void note_particle(pks_pkg::particle_in_t p);
        logic [63:0] k;
        int slot;
        pks_pkg::particle_out_t o;
        k = {32'd0, p.pos_x} * {51'd0, grid_ny} + {32'd0, p.pos_y};
        if (held.size() < CAP)
        begin
            slot = 0;
            while (slot < held.size() && held_key[slot] <= k)
                slot++;
            held.insert(slot, p);
            held_key.insert(slot, k);
        end
        if (p.last)
        begin
            for (int i = 0; i < held.size(); i++)
            begin
                o.out_pos_x = held[i].pos_x;
                o.out_pos_y = held[i].pos_y;
                o.out_pos_z = held[i].pos_z;
                o.out_vel_x = held[i].vel_x;
                o.out_vel_y = held[i].vel_y;
                o.out_vel_z = held[i].vel_z;
                o.out_last  = (i == held.size() - 1);
                expected_out.push_back(o);
            end
            held.delete();
            held_key.delete();
        end
    endfunction

    function void check_result(pks_pkg::particle_out_t r);
        pks_pkg::particle_out_t e;
        if (expected_out.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transfer %h", r);
            return;
        end
        e = expected_out.pop_front();
        if (r !== e)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h actual %h", e, r);
        end
    endfunction
endclass

module particle_key_sort_test
    import pks_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic          clk = 0;
    logic          rst_n = 0;
    logic          item_valid = 0;
    logic          item_stall;
    particle_in_t  item = '0;
    logic          res_valid;
    logic          res_stall = 0;
    particle_out_t res;
    logic          cfg_we = 0;
    logic [12:0]   cfg_data = '0;

    sort_scoreboard sb = new();
    int  quiet_cycles = 0;
    int  sets_done = 0;
    int  res_wait = 0;

    particle_key_sort u_top (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_stall(item_stall),
        .item(item), .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Result side: after each transfer, stall for a drawn number of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                sb.check_result(res);
                res_wait = $urandom_range(0, 9);
                res_stall <= (res_wait != 0);
            end
            else if (res_stall)
            begin
                res_wait = res_wait - 1;
                if (res_wait <= 0)
                    res_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_particle(input particle_in_t p, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= p;
        do @(posedge clk); while (item_stall);
        sb.note_particle(p);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.expected_out.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_grid(input logic [12:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.grid_ny = v;
    endtask

    function automatic particle_in_t rand_particle(input bit lst, input bit narrow);
        particle_in_t p;
        p.pos_x = narrow ? 32'($urandom_range(0, 7)) : $urandom;
        p.pos_y = narrow ? 32'($urandom_range(0, 7)) : $urandom;
        p.pos_z = $urandom;
        p.vel_x = $urandom;
        p.vel_y = $urandom;
        p.vel_z = $urandom;
        p.last  = lst;
        return p;
    endfunction

    task automatic send_set(input int n, input bit narrow, input bit burst);
        for (int i = 0; i < n; i++)
            send_particle(rand_particle(i == n - 1, narrow), burst);
    endtask

    initial
    begin
        particle_in_t p;
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the key fields at the reset grid, plus a lone last item.
        p = '0;
        send_particle(p, 1'b0);
        p = '1; p.last = 1'b0;
        send_particle(p, 1'b0);
        p = '0; p.pos_y = 32'hffffffff; p.vel_x = 32'sh80000000;
        send_particle(p, 1'b0);
        p = '0; p.pos_x = 32'h1; p.vel_y = 32'sh7fffffff; p.last = 1'b1;
        send_particle(p, 1'b0);
        send_set(1, 1'b0, 1'b0);
        drain();

        // Zero grid: key is pos_y alone, and ties must keep arrival order.
        write_grid(13'd0);
        send_set(8, 1'b1, 1'b1);
        drain();

        // Capacity: 66 particles, the last two dropped but the set still sent.
        write_grid(13'h1fff);
        send_set(66, 1'b0, 1'b1);
        drain();

        write_grid(13'd4096);
        send_set(6, 1'b1, 1'b0);
        drain();

        write_grid(13'd1);
        for (int s = 0; s < 6; s++)
        begin
            n = $urandom_range(1, 10);
            send_set(n, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            if (s == 2)
            begin
                drain();
                write_grid(13'($urandom_range(1, 4096)));
            end
        end
        drain();

        if (sb.mismatches == 0 && sb.expected_out.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
